### rtl/core/kbtr_pkg.sv
`timescale 1ns / 1ps
package kbtr_pkg;

	localparam logic [31:0] DELAY_RESET = 32'd1800;
	localparam logic [31:0] RATE_RESET  = 32'd60000;

	localparam int REL_BIT = 7; // 0x80 marks a key release

	localparam logic [6:0] KEY_LSHIFT = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT = 7'h36;
	localparam logic [6:0] KEY_LCTRL  = 7'h1D;
	localparam logic [6:0] KEY_CAPS   = 7'h3A;

	localparam logic [7:0] REG_DELAY = 8'd0;
	localparam logic [7:0] REG_RATE  = 8'd1;

	typedef struct packed {
		logic       code_valid;
		logic [7:0] scancode;
	} tick_t;

	typedef struct packed {
		logic       fire_valid;
		logic [6:0] fire_code;
		logic       shift_on;
		logic       caps_on;
		logic       ctrl_on;
	} fire_t;

	typedef struct packed {
		logic [7:0]  index;
		logic [31:0] value;
	} cfg_t;

	typedef struct packed {
		logic [31:0] delay_ticks;
		logic [31:0] rate_ticks;
	} cfg_regs_t;

endpackage

### rtl/core/kbtr_chan_if.sv
`timescale 1ns / 1ps
interface kbtr_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/kbtr_mod_unit.sv
`timescale 1ns / 1ps
// Restoring remainder unit, one dividend bit per cycle.
module kbtr_mod_unit #(
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COUNT_BITS-1:0] dividend,
	input  logic [31:0]           divisor,
	output logic                  busy,
	output logic                  done,
	output logic                  rem_zero
);
	localparam int CW = (COUNT_BITS > 1) ? $clog2(COUNT_BITS) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [COUNT_BITS-1:0] dvd_q;
	logic [31:0]           dvs_q;
	logic [31:0]           rem_q;
	logic [32:0]           trial;
	logic [31:0]           rem_nxt;

	always_comb begin
		trial = {rem_q, dvd_q[COUNT_BITS-1]};
		if (trial >= {1'b0, dvs_q}) begin
			rem_nxt = 32'(trial - {1'b0, dvs_q});
		end else begin
			rem_nxt = trial[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(COUNT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COUNT_BITS-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("remainder done without a run");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder unit started while busy");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < dvs_q)
		else $error("partial remainder not below divisor");
endmodule

### rtl/core/kbtr_scan_seq.sv
`timescale 1ns / 1ps
module kbtr_scan_seq #(
	parameter int NUM_KEYS   = 128,
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kbtr_pkg::tick_t     in_data,
	input  kbtr_pkg::cfg_regs_t regs,
	output logic                res_valid,
	input  logic                res_ready,
	output kbtr_pkg::fire_t     res
);
	import kbtr_pkg::*;

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_INC,
		S_DIV,
		S_FIN
	} state_t;

	state_t                state_q;
	logic [NUM_KEYS-1:0]   held_q;
	logic [KW-1:0]         k_q;
	logic                  fire_q;
	logic [KW-1:0]         fkey_q;
	logic                  shift_q;
	logic                  caps_q;
	logic                  ctrl_q;
	logic [COUNT_BITS-1:0] cnt_mem [NUM_KEYS];
	logic [COUNT_BITS-1:0] rd_q;

	logic                  in_fire;
	logic [6:0]            key7;
	logic [KW-1:0]         idx;
	logic                  in_range;
	logic                  is_rel;
	logic                  is_shift;
	logic                  is_ctrl;
	logic                  is_caps;
	logic                  new_press;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  past_delay;
	logic                  div_start;
	logic                  div_busy;
	logic                  div_done;
	logic                  div_zero;
	logic                  last_key;
	logic                  mem_we;
	logic [KW-1:0]         mem_wa;
	logic [COUNT_BITS-1:0] mem_wd;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign key7      = in_data.scancode[6:0];
	assign idx       = key7[KW-1:0];
	assign in_range  = {1'b0, key7} < 8'(NUM_KEYS);
	assign is_rel    = in_data.scancode[REL_BIT];
	assign is_shift  = key7 inside {KEY_LSHIFT, KEY_RSHIFT};
	assign is_ctrl   = (key7 == KEY_LCTRL);
	assign is_caps   = (key7 == KEY_CAPS);
	assign new_press = in_data.code_valid && !is_rel && in_range && !held_q[idx];

	assign cnt_inc    = rd_q + COUNT_BITS'(1);
	assign past_delay = 32'(cnt_inc) > regs.delay_ticks;
	assign div_start  = (state_q == S_INC) && (cnt_inc != COUNT_BITS'(1)) && past_delay
		&& (regs.rate_ticks != '0);
	assign last_key   = (k_q == KW'(NUM_KEYS - 1));

	// one write port: zero on a fresh press, incremented count during the scan
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx;
		mem_wd = '0;
		if (state_q == S_INC) begin
			mem_we = 1'b1;
			mem_wa = k_q;
			mem_wd = cnt_inc;
		end else if (in_fire && new_press) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cnt_mem[mem_wa] <= mem_wd;
		end
		rd_q <= cnt_mem[k_q];
	end

	kbtr_mod_unit #(
		.COUNT_BITS(COUNT_BITS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cnt_inc - regs.delay_ticks[COUNT_BITS-1:0]),
		.divisor  (regs.rate_ticks),
		.busy     (div_busy),
		.done     (div_done),
		.rem_zero (div_zero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q  <= '0;
			k_q     <= '0;
			fire_q  <= 1'b0;
			fkey_q  <= '0;
			shift_q <= 1'b0;
			caps_q  <= 1'b0;
			ctrl_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						fire_q  <= 1'b0;
						fkey_q  <= '0;
						k_q     <= '0;
						state_q <= S_READ;
						if (in_data.code_valid) begin
							if (is_rel) begin
								if (in_range) begin
									held_q[idx] <= 1'b0;
								end
								if (is_shift) begin
									shift_q <= 1'b0;
								end
								if (is_ctrl) begin
									ctrl_q <= 1'b0;
								end
								state_q <= S_FIN;
							end else begin
								if (new_press) begin
									held_q[idx] <= 1'b1;
								end
								if (is_shift) begin
									shift_q <= 1'b1;
									state_q <= S_FIN;
								end else if (is_ctrl) begin
									ctrl_q  <= 1'b1;
									state_q <= S_FIN;
								end else if (is_caps) begin
									caps_q  <= !caps_q;
									state_q <= S_FIN;
								end
							end
						end
					end
				end
				S_READ: begin
					// rd_q holds this key's count on the next cycle
					if (held_q[k_q]) begin
						state_q <= S_INC;
					end else if (last_key) begin
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				S_INC: begin
					if (cnt_inc == COUNT_BITS'(1)) begin
						fire_q <= 1'b1;
						fkey_q <= k_q;
					end
					if (div_start) begin
						state_q <= S_DIV;
					end else if (last_key) begin
						state_q <= S_FIN;
					end else begin
						k_q     <= k_q + KW'(1);
						state_q <= S_READ;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_zero) begin
							fire_q <= 1'b1;
							fkey_q <= k_q;
						end
						if (last_key) begin
							state_q <= S_FIN;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid      = (state_q == S_FIN);
	assign res.fire_valid = fire_q;
	assign res.fire_code  = 7'(fkey_q);
	assign res.shift_on   = shift_q;
	assign res.caps_on    = caps_q;
	assign res.ctrl_on    = ctrl_q;

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("accepted tick did not start work");
	a_div_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> div_busy || div_done)
		else $error("waiting on an idle remainder unit");
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.fire_valid |-> res.fire_code == '0)
		else $error("key code reported with no fire");
endmodule

### rtl/core/keyboard_typematic_repeat_core.sv
`timescale 1ns / 1ps
// Sequencing: a release or modifier tick goes from the accepting edge straight to the
// result state; a scanning tick walks every key, reading each idle key, reading and
// incrementing each held key, and running the remainder test for a held key past the
// delay, before the result register is loaded.
// Throughput: one tick at a time; the next is taken while the last result waits.
// Reset: async active low; clears held keys, flags, sequencer, delay=1800, rate=60000.
module keyboard_typematic_repeat_core #(
	parameter int NUM_KEYS   = 128,
	parameter int COUNT_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	kbtr_chan_if.sink   tick,
	kbtr_chan_if.source result,
	kbtr_chan_if.sink   cfg
);
	import kbtr_pkg::*;

	cfg_regs_t regs_q;
	tick_t     tick_data;
	cfg_t      cfg_data;
	fire_t     res;
	fire_t     out_q;
	logic      out_valid_q;
	logic      res_valid;
	logic      res_ready;
	logic      tick_ready;

	assign tick_data = tick.data;
	assign cfg_data  = cfg.data;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.delay_ticks <= DELAY_RESET;
			regs_q.rate_ticks  <= RATE_RESET;
		end else if (cfg.valid) begin
			if (cfg_data.index == REG_DELAY) begin
				regs_q.delay_ticks <= cfg_data.value;
			end else if (cfg_data.index == REG_RATE) begin
				regs_q.rate_ticks <= cfg_data.value;
			end
		end
	end

	kbtr_scan_seq #(
		.NUM_KEYS   (NUM_KEYS),
		.COUNT_BITS (COUNT_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tick.valid),
		.in_ready  (tick_ready),
		.in_data   (tick_data),
		.regs      (regs_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign tick.ready = tick_ready;
	assign res_ready  = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;
endmodule
